>>> rtl/core/hcfe_pkg.sv
// hcfe_pkg: shared types and constants of the heightmap column face emitter
`timescale 1ns / 1ps

package hcfe_pkg;

  localparam int unsigned HeightW = 20;
  localparam int unsigned CellW   = 6;
  localparam int unsigned VertW   = 17;
  localparam int unsigned FaceN   = 5;
  localparam int unsigned CfgW    = 7;

  localparam logic [CfgW-1:0]  ChunkSizeRst = 7'd32;
  localparam logic [VertW-1:0] VertStep     = 17'd4;

  typedef logic signed [HeightW-1:0] height_t;

  // -1000.0 in Q11.8
  localparam height_t EdgeLow = -20'sd256000;

  typedef enum logic [2:0] {
    FACE_TOP   = 3'd0,
    FACE_NORTH = 3'd1,
    FACE_SOUTH = 3'd2,
    FACE_EAST  = 3'd3,
    FACE_WEST  = 3'd4
  } face_e;

  typedef logic [FaceN-1:0] face_mask_t;

  // one line store entry: a is the previous row, b the row before that
  typedef struct packed {
    height_t b;
    height_t a;
  } line_entry_t;

  // result payload, first field in the highest bits
  typedef struct packed {
    logic [VertW-1:0] base_vertex;
    height_t          bottom_height;
    height_t          top_height;
    face_e            face;
    logic [CellW-1:0] cell_z;
    logic [CellW-1:0] cell_x;
  } quad_t;

  // one decoded cell handed to the quad emitter
  typedef struct packed {
    face_mask_t                mask;
    logic [CellW-1:0]          cell_x;
    logic [CellW-1:0]          cell_z;
    height_t                   top;
    height_t [FaceN-1:0]       bottom;
    logic                      chunk_end;
    logic                      clr_before;
    logic                      clr_after;
  } cell_req_t;

endpackage

>>> rtl/core/hcfe_line_mem.sv
// hcfe_line_mem: two-row line store, one write port and two registered read ports
`timescale 1ns / 1ps

module hcfe_line_mem
  import hcfe_pkg::*;
#(
  parameter int unsigned Depth = 65,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  line_entry_t       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr0_i,
  input  logic [AddrW-1:0]  raddr1_i,
  output line_entry_t       rdata0_o,
  output line_entry_t       rdata1_o
);

  line_entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the entry as it was before a write in the same cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

>>> rtl/core/hcfe_quad_emitter.sv
// hcfe_quad_emitter: serializes the quads of one cell into the result register
`timescale 1ns / 1ps

module hcfe_quad_emitter
  import hcfe_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  cell_req_t                 req_i,
  output logic                      req_ready_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // cell_x, cell_z, face, top_height, bottom_height, base_vertex
  output logic [$bits(quad_t)-1:0]  m_axis_tdata,
  output logic                      m_axis_tlast,
  // chunk_end
  output logic [0:0]                m_axis_tuser
);

  logic                busy_q, busy_d;
  face_mask_t          mask_q, mask_rest;
  logic [CellW-1:0]    cx_q, cz_q;
  height_t             top_q;
  height_t [FaceN-1:0] bot_q;
  logic                end_q, clr_after_q;
  logic [VertW-1:0]    vc_q, vc_d;
  logic                out_valid_q, out_valid_d;
  quad_t               out_quad_q, out_quad_d;
  logic                out_last_q, out_end_q;
  logic                out_free, emit, quad_last, load;
  face_e               face_sel;

  // lowest pending face goes first
  always_comb begin
    face_sel = FACE_TOP;
    for (int k = FaceN - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        face_sel = face_e'(k[2:0]);
      end
    end
  end

  always_comb begin
    out_free    = !out_valid_q || m_axis_tready;
    emit        = busy_q && out_free;
    mask_rest   = mask_q & (mask_q - 1'b1);
    quad_last   = (mask_rest == '0);
    req_ready_o = !busy_q || (emit && quad_last);
    load        = req_valid_i && req_ready_o;

    out_quad_d.cell_x        = cx_q;
    out_quad_d.cell_z        = cz_q;
    out_quad_d.face          = face_sel;
    out_quad_d.top_height    = top_q;
    out_quad_d.bottom_height = bot_q[face_sel];
    out_quad_d.base_vertex   = vc_q;

    vc_d = vc_q;
    if (emit) begin
      vc_d = (quad_last && clr_after_q) ? '0 : vc_q + VertStep;
    end
    // a cell without quads still carries its counter clears
    if (load && (req_i.clr_before || ((req_i.mask == '0) && req_i.clr_after))) begin
      vc_d = '0;
    end

    busy_d = busy_q;
    if (load) begin
      busy_d = (req_i.mask != '0);
    end else if (emit && quad_last) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      vc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      vc_q        <= vc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q      <= req_i.mask;
      cx_q        <= req_i.cell_x;
      cz_q        <= req_i.cell_z;
      top_q       <= req_i.top;
      bot_q       <= req_i.bottom;
      end_q       <= req_i.chunk_end;
      clr_after_q <= req_i.clr_after;
    end else if (emit) begin
      mask_q <= mask_rest;
    end
    if (emit) begin
      out_quad_q <= out_quad_d;
      out_last_q <= quad_last;
      out_end_q  <= end_q && quad_last;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_quad_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_end_q;

  a_busy_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (mask_q != '0))
    else $error("emitter busy with no face pending");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_end_q) |-> out_last_q)
    else $error("chunk end flagged on a quad that is not the last of its cell");

  a_vertex_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !quad_last) |=> (vc_q == $past(vc_q) + VertStep))
    else $error("base vertex did not advance by one quad within a cell");

endmodule

>>> rtl/core/heightmap_column_face_emitter_unit.sv
// heightmap_column_face_emitter_unit: top level, sample tracking, line store and cell decode
`timescale 1ns / 1ps

// Height samples of a chunk enter on the s_axis channel in x-major order,
// (size+1)^2 per chunk; tuser[0] set marks the first sample of a chunk.
// Each sample (i+1, j) with j below size closes cell (i, j), whose quads
// leave on the m_axis channel: the top quad, then north, south, east and west
// side quads where the cell stands above that neighbour. tlast marks the
// last quad of a request, tuser[0] the last quad of the chunk.
// The chunk size register is written on the cfg channel, which is always ready.
// A request is registered in the decode stage, then in the quad emitter, which
// hands its quads (one to five) to the result register, one a cycle while that
// register is free. A request waits in the decode stage until the emitter hands
// out the last quad before it. The line store is read at acceptance and written
// back when the request leaves the decode stage. Reset clears the sample
// position, the vertex counter and the output valid, and sets the chunk size to
// 32; line store contents stay undefined until the first rows are written. When
// the receiver stalls, the result register holds, the emitter and decode stage
// fill, and s_axis_tready drops.
module heightmap_column_face_emitter_unit
  import hcfe_pkg::*;
#(
  parameter int unsigned MaxChunk = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // height
  input  logic [23:0]               s_axis_tdata,
  // chunk_start
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // cell_x, cell_z, face, top_height, bottom_height, base_vertex
  output logic [$bits(quad_t)-1:0]  m_axis_tdata,
  output logic                      m_axis_tlast,
  // chunk_end
  output logic [0:0]                m_axis_tuser
);

  localparam int unsigned Depth = MaxChunk + 1;
  localparam int unsigned PosW  = $clog2(Depth);

  logic [CfgW-1:0] cfg_size_q;
  logic [PosW-1:0] size;
  logic [PosW-1:0] x_q, x_d, z_q, z_d, cur_x, cur_z;
  logic            wrap_d;
  logic [PosW-1:0] raddr1;
  logic            in_fire;

  logic            s1_valid_q;
  height_t         s1_h_q;
  logic [PosW-1:0] s1_x_q, s1_z_q;
  logic            s1_start_q, s1_wrap_q;
  logic            s1_adv;
  height_t         prev_a_q;

  line_entry_t     rd0, rd1, wr_entry;
  cell_req_t       req;
  logic            req_ready;

  logic            emit_cell;
  logic [PosW-1:0] cell_i;
  height_t         h, hn, hs, he, hw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= ChunkSizeRst;
    end else if (cfg_valid_i) begin
      cfg_size_q <= cfg_data_i;
    end
  end

  // effective size clamped to 1..MaxChunk
  always_comb begin
    if (cfg_size_q == '0) begin
      size = PosW'(1);
    end else if (32'(cfg_size_q) > MaxChunk) begin
      size = PosW'(MaxChunk);
    end else begin
      size = PosW'(cfg_size_q);
    end
  end

  assign s1_adv        = s1_valid_q && req_ready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_x  = s_axis_tuser[0] ? '0 : x_q;
    cur_z  = s_axis_tuser[0] ? '0 : z_q;
    x_d    = cur_x;
    z_d    = cur_z + 1'b1;
    wrap_d = 1'b0;
    if (({1'b0, cur_z} + 1'b1) > {1'b0, size}) begin
      z_d = '0;
      if (cur_x >= size) begin
        x_d    = '0;
        wrap_d = 1'b1;
      end else begin
        x_d = cur_x + 1'b1;
      end
    end
    // the entry past the store is never used as a neighbour
    raddr1 = (cur_z == PosW'(MaxChunk)) ? cur_z : cur_z + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      z_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        x_q <= x_d;
        z_q <= z_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_h_q     <= s_axis_tdata[HeightW-1:0];
      s1_x_q     <= cur_x;
      s1_z_q     <= cur_z;
      s1_start_q <= s_axis_tuser[0];
      s1_wrap_q  <= wrap_d;
    end
    // previous row at j-1 for the south neighbour
    if (s1_adv) begin
      prev_a_q <= rd0.a;
    end
  end

  assign wr_entry.a = s1_h_q;
  assign wr_entry.b = rd0.a;

  hcfe_line_mem #(
    .Depth (Depth)
  ) u_line_mem (
    .clk_i    (clk_i),
    .we_i     (s1_adv),
    .waddr_i  (s1_z_q),
    .wdata_i  (wr_entry),
    .re_i     (in_fire),
    .raddr0_i (cur_z),
    .raddr1_i (raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // cell decode
  always_comb begin
    emit_cell = (s1_x_q != '0) && (s1_x_q <= size) && (s1_z_q < size);
    cell_i    = s1_x_q - 1'b1;
    h  = rd0.a;
    hn = (({1'b0, s1_z_q} + 1'b1) < {1'b0, size}) ? rd1.a : EdgeLow;
    hs = (s1_z_q != '0) ? prev_a_q : EdgeLow;
    he = (({1'b0, cell_i} + 1'b1) < {1'b0, size}) ? s1_h_q : EdgeLow;
    hw = (cell_i != '0) ? rd0.b : EdgeLow;

    req.mask             = '0;
    req.mask[FACE_TOP]   = emit_cell;
    req.mask[FACE_NORTH] = emit_cell && ($signed(h) > $signed(hn));
    req.mask[FACE_SOUTH] = emit_cell && ($signed(h) > $signed(hs));
    req.mask[FACE_EAST]  = emit_cell && ($signed(h) > $signed(he));
    req.mask[FACE_WEST]  = emit_cell && ($signed(h) > $signed(hw));

    req.cell_x             = CellW'(cell_i);
    req.cell_z             = CellW'(s1_z_q);
    req.top                = h;
    req.bottom[FACE_TOP]   = h;
    req.bottom[FACE_NORTH] = hn;
    req.bottom[FACE_SOUTH] = hs;
    req.bottom[FACE_EAST]  = he;
    req.bottom[FACE_WEST]  = hw;
    req.chunk_end  = emit_cell && (({1'b0, cell_i} + 1'b1) == {1'b0, size})
                     && (({1'b0, s1_z_q} + 1'b1) == {1'b0, size});
    req.clr_before = s1_start_q;
    req.clr_after  = s1_wrap_q;
  end

  hcfe_quad_emitter u_quad_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s1_valid_q),
    .req_i         (req),
    .req_ready_o   (req_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && !req_ready))
    else $error("input stalled while decode stage could move");

endmodule

>>> tb/hcfe_quad_audit.sv
// hcfe_quad_audit: predicts the quads of every accepted sample and compares them on the way out
`timescale 1ns / 1ps

module hcfe_quad_audit
  import hcfe_pkg::*;
#(
  parameter int unsigned MaxChunk = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     s_valid_i,
  input  logic                     s_ready_i,
  input  logic [23:0]              s_data_i,
  input  logic [0:0]               s_user_i,
  input  logic                     m_valid_i,
  input  logic                     m_ready_i,
  input  logic [$bits(quad_t)-1:0] m_data_i,
  input  logic                     m_last_i,
  input  logic [0:0]               m_user_i,
  output int                       mismatches_o,
  output int                       quads_pending_o,
  output int                       quads_seen_o
);

  typedef struct packed {
    quad_t quad;
    logic  last;
    logic  chunk_end;
  } quad_due_t;

  quad_due_t        quads_due[$];
  height_t          prev_row [0:MaxChunk];
  height_t          older_row[0:MaxChunk];
  logic [CfgW-1:0]  chunk_size_q = ChunkSizeRst;
  int unsigned      pos_x = 0;
  int unsigned      pos_z = 0;
  logic [VertW-1:0] vert_count = '0;
  int               mismatches = 0;
  int               quads_seen = 0;
  quad_t            got;
  quad_due_t        want;

  function automatic quad_due_t make_quad(int unsigned i, int unsigned j, face_e face,
                                          height_t top, height_t bottom);
    quad_due_t q;
    q.quad.cell_x        = i[CellW-1:0];
    q.quad.cell_z        = j[CellW-1:0];
    q.quad.face          = face;
    q.quad.top_height    = top;
    q.quad.bottom_height = bottom;
    q.quad.base_vertex   = vert_count;
    q.last               = 1'b0;
    q.chunk_end          = 1'b0;
    vert_count += VertStep;
    return q;
  endfunction

  // quads of the cell that this sample closes, then line store and position update
  function automatic void predict_cell_quads(height_t h_in, logic opens_chunk);
    int unsigned cells, x, z, i, j;
    height_t     top, hn, hs, he, hw;
    quad_due_t   cell_quads[$];
    cells = (chunk_size_q == '0) ? 1 : 32'(chunk_size_q);
    if (cells > MaxChunk) cells = MaxChunk;
    if (opens_chunk) begin
      pos_x = 0;
      pos_z = 0;
      vert_count = '0;
    end
    x = pos_x;
    z = pos_z;
    if (x >= 1 && x <= cells && z < cells) begin
      i = x - 1;
      j = z;
      top = prev_row[j];
      // for indexes below j the stores already hold the next row pair
      hn = (j + 1 < cells) ? prev_row[j + 1] : EdgeLow;
      hs = (j > 0) ? older_row[j - 1] : EdgeLow;
      he = (i + 1 < cells) ? h_in : EdgeLow;
      hw = (i > 0) ? older_row[j] : EdgeLow;
      cell_quads.insert(cell_quads.size(), make_quad(i, j, FACE_TOP, top, top));
      if (top > hn) cell_quads.insert(cell_quads.size(), make_quad(i, j, FACE_NORTH, top, hn));
      if (top > hs) cell_quads.insert(cell_quads.size(), make_quad(i, j, FACE_SOUTH, top, hs));
      if (top > he) cell_quads.insert(cell_quads.size(), make_quad(i, j, FACE_EAST, top, he));
      if (top > hw) cell_quads.insert(cell_quads.size(), make_quad(i, j, FACE_WEST, top, hw));
      cell_quads[cell_quads.size() - 1].last = 1'b1;
      if (i + 1 == cells && j + 1 == cells) begin
        cell_quads[cell_quads.size() - 1].chunk_end = 1'b1;
      end
      foreach (cell_quads[k]) quads_due.insert(quads_due.size(), cell_quads[k]);
    end
    if (z <= MaxChunk) begin
      older_row[z] = prev_row[z];
      prev_row[z]  = h_in;
    end
    if (z + 1 <= cells) begin
      pos_z = z + 1;
    end else begin
      pos_z = 0;
      if (x >= cells) begin
        pos_x = 0;
        vert_count = '0;
      end else begin
        pos_x = x + 1;
      end
    end
  endfunction

  function automatic void match_field(string name, logic signed [31:0] exp_val,
                                      logic signed [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quads_due.delete();
      pos_x = 0;
      pos_z = 0;
      vert_count = '0;
      chunk_size_q = ChunkSizeRst;
    end else begin
      // results first: a quad can never belong to a sample taken at the same edge
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        quads_seen++;
        if (quads_due.size() == 0) begin
          $error("quad for cell (%0d,%0d) face %0d arrived with none expected",
                 got.cell_x, got.cell_z, got.face);
          mismatches++;
        end else begin
          want = quads_due.pop_front();
          match_field("cell_x", 32'(want.quad.cell_x), 32'(got.cell_x));
          match_field("cell_z", 32'(want.quad.cell_z), 32'(got.cell_z));
          match_field("face", 32'(want.quad.face), 32'(got.face));
          match_field("top_height", 32'(want.quad.top_height), 32'(got.top_height));
          match_field("bottom_height", 32'(want.quad.bottom_height),
                      32'(got.bottom_height));
          match_field("base_vertex", 32'(want.quad.base_vertex), 32'(got.base_vertex));
          match_field("last", 32'(want.last), 32'(m_last_i));
          match_field("chunk_end", 32'(want.chunk_end), 32'(m_user_i[0]));
        end
      end
      if (cfg_valid_i && cfg_ready_i) chunk_size_q = cfg_data_i;
      if (s_valid_i && s_ready_i) predict_cell_quads(s_data_i[HeightW-1:0], s_user_i[0]);
    end
    mismatches_o    <= mismatches;
    quads_pending_o <= quads_due.size();
    quads_seen_o    <= quads_seen;
  end

endmodule

>>> tb/tb_heightmap_column_face_emitter_unit.sv
// tb_heightmap_column_face_emitter_unit: sample stimulus, size writes and verdict for the emitter
`timescale 1ns / 1ps

module tb_heightmap_column_face_emitter_unit;
  import hcfe_pkg::*;

  localparam int unsigned MaxChunk     = 64;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles   = 90;
  localparam int unsigned RandomGoal   = 120;
  localparam height_t     HeightMax    = 20'sh7FFFF;
  localparam height_t     HeightMin    = 20'sh80000;

  typedef enum int {
    HGT_TIES,
    HGT_FULL,
    HGT_EDGE
  } height_mix_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SHORT,
    IDLE_MIXED
  } idle_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgW-1:0]          cfg_data_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // height
  logic [23:0]              s_axis_tdata;
  // chunk_start
  logic [0:0]               s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // cell_x, cell_z, face, top_height, bottom_height, base_vertex
  logic [$bits(quad_t)-1:0] m_axis_tdata;
  logic                     m_axis_tlast;
  // chunk_end
  logic [0:0]               m_axis_tuser;

  int          mismatches;
  int          quads_pending;
  int          quads_seen;
  int unsigned cycles = 0;
  int          samples_sent = 0;
  int          size_writes = 0;
  int          shrinks = 0;
  int          stall_asks = 0;
  int          stalls_done = 0;
  idle_e       idle_mode = IDLE_MIXED;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  heightmap_column_face_emitter_unit #(
    .MaxChunk(MaxChunk)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  hcfe_quad_audit #(
    .MaxChunk(MaxChunk)
  ) quad_audit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_i      (s_axis_tready),
    .s_data_i       (s_axis_tdata),
    .s_user_i       (s_axis_tuser),
    .m_valid_i      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_data_i       (m_axis_tdata),
    .m_last_i       (m_axis_tlast),
    .m_user_i       (m_axis_tuser),
    .mismatches_o   (mismatches),
    .quads_pending_o(quads_pending),
    .quads_seen_o   (quads_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_heightmap_column_face_emitter_unit failed");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == IDLE_NONE || r < 55) return 0;
    if (idle_mode == IDLE_SHORT || r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic height_t pick_height(height_mix_e mix);
    int r;
    r = $urandom_range(0, 3);
    case (mix)
      HGT_TIES: return height_t'($signed($urandom_range(0, 6)) - 3);
      HGT_FULL: return height_t'($urandom());
      default: begin
        // around the edge sentinel and at the range limits
        if (r == 0) return HeightMax;
        if (r == 1) return HeightMin;
        return height_t'(EdgeLow + ($signed($urandom_range(0, 4)) - 2));
      end
    endcase
  endfunction

  task automatic offer_sample(input height_t h, input logic opens_chunk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, h};
    s_axis_tuser  <= opens_chunk;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  task automatic send_run(input int unsigned count, input logic opens_chunk,
                          input height_mix_e mix);
    for (int unsigned k = 0; k < count; k++) begin
      offer_sample(pick_height(mix), opens_chunk && k == 0);
    end
  endtask

  // sender pauses until every quad is out and the decode stage has emptied
  task automatic drain_quads();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (quads_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_chunk_size(input logic [CfgW-1:0] size_val);
    drain_quads();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_writes++;
  endtask

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (stalls_done != stall_asks) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        stalls_done++;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned      cells, full, count, phase, first_random, pick;
    logic [CfgW-1:0]  size_val;
    height_mix_e      mix;
    logic             restart;
    height_t          corner;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size 0 acts as one cell: only the first sample of each chunk matters,
    // later chunks start by wrapping rather than by chunk_start
    set_chunk_size(7'd0);
    for (int c = 0; c < 4; c++) begin
      corner = (c == 0) ? HeightMax : (c == 1) ? HeightMin :
               (c == 2) ? EdgeLow : height_t'(EdgeLow + 1);
      offer_sample(corner, c == 0);
      repeat (3) offer_sample(pick_height(HGT_EDGE), 1'b0);
    end

    // two by two cells with mixed neighbour ordering
    set_chunk_size(7'd2);
    for (int k = 0; k < 9; k++) begin
      offer_sample(height_t'($signed((k * 7) % 5) - 2), k == 0);
    end

    // oversized value clamps to the largest chunk: one full row and a bit
    set_chunk_size(7'd127);
    idle_mode = IDLE_SHORT;
    send_run(MaxChunk + 11, 1'b1, HGT_FULL);

    first_random = samples_sent;
    phase = 0;
    while (phase < 2 || samples_sent - first_random < RandomGoal) begin
      pick = $urandom_range(0, 99);
      if (phase == 1) size_val = 7'd6;
      else if (pick < 12) size_val = 7'd0;
      else if (pick < 20) size_val = CfgW'($urandom_range(8, 10));
      else size_val = CfgW'($urandom_range(1, 7));
      set_chunk_size(size_val);
      cells = (size_val == '0) ? 1 : 32'(size_val);
      full = (cells + 1) * (cells + 1);
      mix = height_mix_e'($urandom_range(0, 2));
      idle_mode = (phase == 1 || phase % 4 == 3) ? IDLE_NONE : IDLE_MIXED;
      // long receiver hold while samples keep coming
      if (phase == 1) stall_asks++;
      restart = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        count = ($urandom_range(0, 99) < 15) ? $urandom_range(1, full - 1) : full;
        send_run(count, restart || ($urandom_range(0, 1) == 1), mix);
        restart = (count != full);
      end
      // size shrinks while a chunk is half done
      if (cells >= 3 && $urandom_range(0, 99) < 30) begin
        send_run($urandom_range(1, full - 1), 1'b1, mix);
        set_chunk_size(CfgW'($urandom_range(1, cells - 1)));
        send_run($urandom_range(1, 3 * cells), 1'b0, mix);
        shrinks++;
      end
      phase++;
    end

    drain_quads();
    $display("covered %0d samples, %0d quads checked, %0d chunk size writes in %0d phases",
             samples_sent, quads_seen, size_writes, phase);
    $display("sizes 0 to 10 and clamped 127, %0d mid-chunk shrinks, %0d long receiver holds",
             shrinks, stalls_done);
    if (mismatches == 0 && quads_pending == 0) begin
      $display("tb_heightmap_column_face_emitter_unit passed");
    end else begin
      $display("tb_heightmap_column_face_emitter_unit failed");
    end
    $finish;
  end

endmodule
